### sv/atti_pkg.sv
// ----------------------------------------------------------------------------
// atti_pkg
// Shared widths, ROM contents and helper functions for the attenuation table
// interpolator.
// ----------------------------------------------------------------------------
package atti_pkg;

  localparam int unsigned DEF_TABLE_ENTRIES  = 12;
  localparam int unsigned DEF_COEF_FRAC_BITS = 24;

  localparam int unsigned ROM_DEPTH    = 32;
  localparam int unsigned IDX_W        = $clog2(ROM_DEPTH);
  localparam int unsigned RANGE_W      = 20;
  localparam int unsigned RANGE_FRAC_W = 4;
  localparam int unsigned BP_W         = RANGE_W - RANGE_FRAC_W;
  localparam int unsigned COEF_W       = 25;
  localparam int unsigned Q_W          = 31;
  localparam int unsigned T_W          = 16;
  localparam int unsigned RECIP_W      = 26;
  localparam int unsigned NUM_COEF     = 3;
  localparam int unsigned QUEUE_DEPTH  = 2;

  localparam logic [T_W-1:0]    T_MAX   = {T_W{1'b1}};
  localparam logic [T_W-1:0]    T_HALF  = T_W'(1) << (T_W - 1);
  localparam logic [COEF_W-1:0] OUT_MAX = {COEF_W{1'b1}};

  // Table values are given in units of 1e-7.
  localparam logic [63:0] UNIT_SCALE = 64'd10000000;
  localparam logic [63:0] UNIT_HALF  = 64'd5000000;

  localparam int unsigned COEF_CST  = 0;
  localparam int unsigned COEF_LIN  = 1;
  localparam int unsigned COEF_QUAD = 2;

  typedef logic [31:0]      raw_rom_t   [ROM_DEPTH];
  typedef logic [Q_W-1:0]   q_rom_t     [ROM_DEPTH];
  typedef logic [BP_W-1:0]  bp_rom_t    [ROM_DEPTH];
  typedef logic [RECIP_W-1:0] recip_rom_t [ROM_DEPTH];

  typedef struct packed {
    logic [IDX_W-1:0]   seg;
    logic [RANGE_W-1:0] diff;
  } seg_item_t;

  // Breakpoints in whole distance units.
  localparam bp_rom_t BP_ROM = '{
    16'd7, 16'd13, 16'd20, 16'd32, 16'd50, 16'd65, 16'd100, 16'd160,
    16'd200, 16'd325, 16'd600, 16'd3250, 16'd0, 16'd0, 16'd0, 16'd0,
    16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
    16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0
  };

  // Rounded 2^32 / segment width, segment width in range units (Q.4).
  // A segment without a positive width holds zero, which forces the weight to zero.
  localparam recip_rom_t RECIP_ROM = '{
    26'd44739243, 26'd38347922, 26'd22369621, 26'd14913081,
    26'd17895697, 26'd7669584, 26'd4473924, 26'd6710886,
    26'd2147484, 26'd976129, 26'd101296, 26'd0,
    26'd0, 26'd0, 26'd0, 26'd0, 26'd0, 26'd0, 26'd0, 26'd0,
    26'd0, 26'd0, 26'd0, 26'd0, 26'd0, 26'd0, 26'd0, 26'd0,
    26'd0, 26'd0, 26'd0, 26'd0
  };

  localparam raw_rom_t CST_RAW = '{
    32'd10000000, 32'd10000000, 32'd10000000, 32'd10000000,
    32'd10000000, 32'd10000000, 32'd10000000, 32'd10000000,
    32'd10000000, 32'd10000000, 32'd10000000, 32'd10000000,
    32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0,
    32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0,
    32'd0, 32'd0, 32'd0, 32'd0
  };

  localparam raw_rom_t LIN_RAW = '{
    32'd7000000, 32'd3500000, 32'd2200000, 32'd1400000,
    32'd900000, 32'd700000, 32'd450000, 32'd270000,
    32'd220000, 32'd140000, 32'd70000, 32'd14000,
    32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0,
    32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0,
    32'd0, 32'd0, 32'd0, 32'd0
  };

  localparam raw_rom_t QUAD_RAW = '{
    32'd18000000, 32'd4400000, 32'd2000000, 32'd700000,
    32'd320000, 32'd170000, 32'd75000, 32'd28000,
    32'd19000, 32'd7000, 32'd2000, 32'd70,
    32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0,
    32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0,
    32'd0, 32'd0, 32'd0, 32'd0
  };

  // Converts a table in units of 1e-7 to fixed point, rounding halves up.
  function automatic q_rom_t make_q_rom(raw_rom_t raw, int unsigned frac);
    q_rom_t      rom;
    logic [63:0] scaled;
    for (int i = 0; i < ROM_DEPTH; i++) begin
      scaled = ((64'(raw[i]) << frac) + UNIT_HALF) / UNIT_SCALE;
      rom[i] = Q_W'(scaled);
    end
    return rom;
  endfunction

  // Breakpoint position in range units.
  function automatic logic [RANGE_W-1:0] bp_pos(logic [IDX_W-1:0] i);
    return {BP_ROM[i], {RANGE_FRAC_W{1'b0}}};
  endfunction

endpackage

### sv/attenuation_table_interpolator_unit.sv
// ----------------------------------------------------------------------------
// attenuation_table_interpolator_unit
// Maps a light range to constant, linear and quadratic attenuation terms by
// piecewise-linear interpolation over a fixed breakpoint table.
// ----------------------------------------------------------------------------
//  Channel  Handshake             Payload
//  in       in_valid / in_ready   light_range (Q16.4)
//  out      out_valid / out_ready constant_coef, linear_coef, quadratic_coef (Q1.24)
//
//  The front end classifies a beat in the cycle it is accepted and writes it
//  to a two-entry queue. The back end takes one beat at a time through four
//  steps (load, weight multiply, blend multiply, output) and accepts no new beat
//  until its result is loaded into the output register. A stalled output holds
//  the back end; the queue keeps taking input beats until it is full. Reset
//  empties the queue and the output register.
// ----------------------------------------------------------------------------
module attenuation_table_interpolator_unit #(
  parameter int unsigned TABLE_ENTRIES  = atti_pkg::DEF_TABLE_ENTRIES,
  parameter int unsigned COEF_FRAC_BITS = atti_pkg::DEF_COEF_FRAC_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [atti_pkg::RANGE_W-1:0] light_range,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [atti_pkg::COEF_W-1:0] constant_coef,
  output logic [atti_pkg::COEF_W-1:0] linear_coef,
  output logic [atti_pkg::COEF_W-1:0] quadratic_coef
);
  import atti_pkg::*;

  logic                              push_valid;
  logic                              push_ready;
  seg_item_t                         push_item;
  logic                              pop_valid;
  logic                              pop_ready;
  seg_item_t                         pop_item;
  logic [NUM_COEF-1:0][COEF_W-1:0]   coef;

  atti_front #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_front (
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .light_range(light_range),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  atti_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_item (push_item),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_item  (pop_item)
  );

  atti_back #(
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .item_valid(pop_valid),
    .item_ready(pop_ready),
    .item      (pop_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .coef      (coef)
  );

  assign constant_coef  = coef[COEF_CST];
  assign linear_coef    = coef[COEF_LIN];
  assign quadratic_coef = coef[COEF_QUAD];

endmodule

### sv/atti_front.sv
// ----------------------------------------------------------------------------
// atti_front
// Accepts a light range, classifies it against the breakpoint table and
// forms the segment index and the offset into that segment.
// ----------------------------------------------------------------------------
module atti_front #(
  parameter int unsigned TABLE_ENTRIES = atti_pkg::DEF_TABLE_ENTRIES
) (
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [atti_pkg::RANGE_W-1:0] light_range,
  output logic                         push_valid,
  input  logic                         push_ready,
  output atti_pkg::seg_item_t          push_item
);
  import atti_pkg::*;

  localparam logic [IDX_W-1:0] LAST = IDX_W'(TABLE_ENTRIES - 1);

  logic [ROM_DEPTH-1:0] step;
  logic [ROM_DEPTH-1:0] stop;
  logic [ROM_DEPTH-1:0] first_stop;
  logic [IDX_W-1:0]     seg;
  logic [RANGE_W-1:0]   base;
  logic                 at_low;
  logic                 at_high;

  // Each step bit says the search may move past segment k.
  always_comb begin
    step = '0;
    for (int k = 0; k < ROM_DEPTH - 1; k++) begin
      step[k] = ((k + 2) < TABLE_ENTRIES) && (bp_pos(IDX_W'(k + 1)) <= light_range);
    end
  end

  // The segment is the position of the lowest step bit that is clear.
  assign stop       = ~step;
  assign first_stop = stop & (~stop + ROM_DEPTH'(1));

  always_comb begin
    seg = '0;
    for (int k = 0; k < ROM_DEPTH; k++) begin
      if (first_stop[k]) begin
        seg = IDX_W'(k);
      end
    end
  end

  assign base    = bp_pos(seg);
  assign at_low  = light_range <= bp_pos('0);
  assign at_high = light_range >= bp_pos(LAST);

  // End points use a zero offset, which gives a zero weight and the plain entry.
  always_comb begin
    if (at_low) begin
      push_item.seg  = '0;
      push_item.diff = '0;
    end else if (at_high) begin
      push_item.seg  = LAST;
      push_item.diff = '0;
    end else begin
      push_item.seg  = seg;
      push_item.diff = (light_range > base) ? (light_range - base) : '0;
    end
  end

  assign push_valid = in_valid && !rst;
  assign in_ready   = push_ready && !rst;

endmodule

### sv/atti_queue.sv
// ----------------------------------------------------------------------------
// atti_queue
// Short FIFO of classified items between the front and the back end.
// ----------------------------------------------------------------------------
module atti_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push_valid,
  output logic                push_ready,
  input  atti_pkg::seg_item_t push_item,
  output logic                pop_valid,
  input  logic                pop_ready,
  output atti_pkg::seg_item_t pop_item
);
  import atti_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  seg_item_t        mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = count != CNT_W'(QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_item   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_item;
    end
  end

endmodule

### sv/atti_back.sv
// ----------------------------------------------------------------------------
// atti_back
// Forms the interpolation weight and blends the three coefficients of the
// selected segment, one item at a time, into an output register.
// ----------------------------------------------------------------------------
module atti_back #(
  parameter int unsigned COEF_FRAC_BITS = atti_pkg::DEF_COEF_FRAC_BITS
) (
  input  logic                                                 clk,
  input  logic                                                 rst,
  input  logic                                                 item_valid,
  output logic                                                 item_ready,
  input  atti_pkg::seg_item_t                                  item,
  output logic                                                 out_valid,
  input  logic                                                 out_ready,
  output logic [atti_pkg::NUM_COEF-1:0][atti_pkg::COEF_W-1:0] coef
);
  import atti_pkg::*;

  localparam int unsigned WPROD_W = RANGE_W + RECIP_W + 1;
  localparam int unsigned ACC_W   = Q_W + T_W + 3;

  localparam q_rom_t CST_Q  = make_q_rom(CST_RAW, COEF_FRAC_BITS);
  localparam q_rom_t LIN_Q  = make_q_rom(LIN_RAW, COEF_FRAC_BITS);
  localparam q_rom_t QUAD_Q = make_q_rom(QUAD_RAW, COEF_FRAC_BITS);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_WEIGHT = 4'b0010,
    ST_BLEND  = 4'b0100,
    ST_FINAL  = 4'b1000
  } back_state_t;

  back_state_t state;
  back_state_t state_next;

  logic [IDX_W-1:0]          seg;
  logic [IDX_W-1:0]          seg_nx;
  logic [RANGE_W-1:0]        diff;
  logic [T_W-1:0]            t;
  logic [Q_W-1:0]            base_q  [NUM_COEF];
  logic signed [Q_W:0]       delta_q [NUM_COEF];
  logic signed [ACC_W-1:0]   prod    [NUM_COEF];

  logic [WPROD_W-1:0]        wprod;
  logic [WPROD_W-1:0]        wround;
  logic [WPROD_W-T_W-1:0]    t_wide;
  logic [T_W-1:0]            t_next;
  logic [Q_W-1:0]            q_lo [NUM_COEF];
  logic [Q_W-1:0]            q_hi [NUM_COEF];
  logic signed [ACC_W-1:0]   acc  [NUM_COEF];
  logic [Q_W-1:0]            blended [NUM_COEF];
  logic                      load_out;

  assign seg_nx = seg + IDX_W'(1);

  always_comb begin
    q_lo[COEF_CST]  = CST_Q[seg];
    q_hi[COEF_CST]  = CST_Q[seg_nx];
    q_lo[COEF_LIN]  = LIN_Q[seg];
    q_hi[COEF_LIN]  = LIN_Q[seg_nx];
    q_lo[COEF_QUAD] = QUAD_Q[seg];
    q_hi[COEF_QUAD] = QUAD_Q[seg_nx];
  end

  // Weight t = round(diff * recip / 2^16), limited to just below one.
  assign wprod  = WPROD_W'(diff) * WPROD_W'(RECIP_ROM[seg]);
  assign wround = wprod + WPROD_W'(T_HALF);
  assign t_wide = wround[WPROD_W-1:T_W];
  assign t_next = (t_wide > (WPROD_W-T_W)'(T_MAX)) ? T_MAX : T_W'(t_wide);

  // a*(1-t) + b*t is computed as a*2^16 + (b-a)*t, which is exact.
  always_comb begin
    for (int c = 0; c < NUM_COEF; c++) begin
      acc[c] = $signed(ACC_W'({base_q[c], {T_W{1'b0}}})) + prod[c]
             + $signed(ACC_W'(T_HALF));
      blended[c] = acc[c][Q_W+T_W-1:T_W];
    end
  end

  assign item_ready = state == ST_IDLE;
  assign load_out   = (state == ST_FINAL) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (item_valid) begin
          state_next = ST_WEIGHT;
        end
      end
      ST_WEIGHT: state_next = ST_BLEND;
      ST_BLEND:  state_next = ST_FINAL;
      ST_FINAL: begin
        if (load_out) begin
          state_next = ST_IDLE;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      seg  <= item.seg;
      diff <= item.diff;
    end
    if (state == ST_WEIGHT) begin
      t <= t_next;
      for (int c = 0; c < NUM_COEF; c++) begin
        base_q[c]  <= q_lo[c];
        delta_q[c] <= $signed({1'b0, q_hi[c]}) - $signed({1'b0, q_lo[c]});
      end
    end
    if (state == ST_BLEND) begin
      for (int c = 0; c < NUM_COEF; c++) begin
        prod[c] <= ACC_W'(delta_q[c]) * $signed(ACC_W'(t));
      end
    end
    if (load_out) begin
      for (int c = 0; c < NUM_COEF; c++) begin
        coef[c] <= (blended[c] > Q_W'(OUT_MAX)) ? OUT_MAX : COEF_W'(blended[c]);
      end
    end
  end

endmodule
